// ===== rtl/slcfr_pkg.sv =====
`default_nettype none

package slcfr_pkg;

	// payload offset / length width
	localparam int OFFSET_BITS = 17;

	// item commands
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// header sync and trailer bytes
	localparam logic [7:0] SYNC_A   = 8'hDF;
	localparam logic [7:0] SYNC_B   = 8'hFD;
	localparam logic [7:0] TRAIL_CR = 8'h0D;
	localparam logic [7:0] TRAIL_LF = 8'h0A;

	// idle timeout after reset
	localparam logic [7:0] TIMEOUT_RESET = 8'd3;

	// bytes of the header block kept in the store (last one is taken live)
	localparam int HDR_DEPTH = 7;
	localparam logic [2:0] HDR_LAST = 3'd7;

	// receiver phase codes
	localparam logic [1:0] PHASE_HUNT    = 2'd0;
	localparam logic [1:0] PHASE_PAYLOAD = 2'd1;
	localparam logic [1:0] PHASE_TRAILER = 2'd2;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic                   payload_valid;
		logic [7:0]             payload_byte;
		logic [OFFSET_BITS-1:0] payload_offset;
		logic                   header_accepted;
		logic                   length_rejected;
		logic                   frame_complete;
		logic                   frame_abort;
		logic [1:0]             phase;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/sync_length_crlf_frame_receiver_unit.sv =====
// A result beat is registered and appears in the cycle after its item beat is accepted.
// Throughput: one item per cycle; all deframing is done in the accepting cycle.
// An item is taken while the output register holds a beat, as long as it drains.
// Reset (arst_n low, asynchronous): header hunt, idle timeout expired,
// timeout reload 3, frame length 0, output register empty.
`default_nettype none

module sync_length_crlf_frame_receiver_unit
	import slcfr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic    item_valid,
	output      logic    item_stall,
	input  wire item_t   item,
	output      logic    result_valid,
	input  wire logic    result_stall,
	output      result_t result
);

	// state
	logic [7:0]             timeout_reload_q;
	logic [7:0]             idle_count_q;
	logic                   header_ok_q;
	logic                   payload_done_q;
	logic [OFFSET_BITS-1:0] byte_count_q;
	logic [2:0]             slot_q;
	logic [OFFSET_BITS-1:0] frame_len_q;
	logic [7:0]             hdr_q [HDR_DEPTH];
	logic                   result_valid_q;
	result_t                result_q;

	// next state
	logic [7:0]             idle_count_d;
	logic                   header_ok_d;
	logic                   payload_done_d;
	logic [OFFSET_BITS-1:0] byte_count_d;
	logic [2:0]             slot_d;
	logic [OFFSET_BITS-1:0] frame_len_d;
	logic                   hdr_we;
	logic [2:0]             hdr_wa;
	result_t                res;
	logic [31:0]            hdr_len;
	logic                   sync_ok;
	logic                   item_accept;

	assign item_stall   = result_valid_q && result_stall;
	assign item_accept  = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// header decode for the last byte of a block
	assign sync_ok = (hdr_q[0] == SYNC_A) && (hdr_q[1] == SYNC_A) &&
		(hdr_q[2] == SYNC_B) && (hdr_q[3] == SYNC_B);
	assign hdr_len = {hdr_q[4], hdr_q[5], hdr_q[6], item.rx_byte};

	// deframing for one beat
	always_comb begin
		idle_count_d   = idle_count_q;
		header_ok_d    = header_ok_q;
		payload_done_d = payload_done_q;
		byte_count_d   = byte_count_q;
		slot_d         = slot_q;
		frame_len_d    = frame_len_q;
		hdr_we         = 1'b0;
		hdr_wa         = slot_q;
		res            = '0;

		if (item.command == CMD_TICK) begin
			if (idle_count_q != 8'd0) begin
				idle_count_d = idle_count_q - 8'd1;
			end
		end else begin
			// expired timeout: start fresh before this byte
			if (idle_count_q == 8'd0) begin
				header_ok_d    = 1'b0;
				payload_done_d = 1'b0;
				byte_count_d   = '0;
				slot_d         = '0;
			end
			idle_count_d = timeout_reload_q;
			hdr_wa       = slot_d;

			if (!header_ok_d) begin
				// header hunt: fill aligned 8-byte block
				hdr_we = (slot_d != HDR_LAST);
				slot_d = slot_d + 3'd1;
				if (hdr_wa == HDR_LAST && sync_ok) begin
					if (|hdr_len[31:OFFSET_BITS]) begin
						res.length_rejected = 1'b1;
					end else if (hdr_len != 32'd0) begin
						frame_len_d         = hdr_len[OFFSET_BITS-1:0];
						header_ok_d         = 1'b1;
						res.header_accepted = 1'b1;
					end
				end
			end else if (!payload_done_d) begin
				// payload pass-through
				res.payload_valid  = 1'b1;
				res.payload_byte   = item.rx_byte;
				res.payload_offset = byte_count_d;
				byte_count_d       = byte_count_d + 1'b1;
				if (byte_count_d == frame_len_q) begin
					payload_done_d = 1'b1;
				end
			end else begin
				// trailer: pairs of CR LF
				if (!slot_d[0]) begin
					hdr_we = 1'b1;
					hdr_wa = 3'd0;
					slot_d = 3'd1;
				end else begin
					slot_d = 3'd0;
					if (hdr_q[0] == TRAIL_CR && item.rx_byte == TRAIL_LF) begin
						res.frame_complete = 1'b1;
					end else begin
						header_ok_d     = 1'b0;
						payload_done_d  = 1'b0;
						byte_count_d    = '0;
						res.frame_abort = 1'b1;
					end
				end
			end
		end

		if (!header_ok_d) begin
			res.phase = PHASE_HUNT;
		end else if (!payload_done_d) begin
			res.phase = PHASE_PAYLOAD;
		end else begin
			res.phase = PHASE_TRAILER;
		end
	end

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_reload_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_reload_q <= cfg_wdata;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_count_q   <= '0;
			header_ok_q    <= 1'b0;
			payload_done_q <= 1'b0;
			byte_count_q   <= '0;
			slot_q         <= '0;
			frame_len_q    <= '0;
		end else if (item_accept) begin
			idle_count_q   <= idle_count_d;
			header_ok_q    <= header_ok_d;
			payload_done_q <= payload_done_d;
			byte_count_q   <= byte_count_d;
			slot_q         <= slot_d;
			frame_len_q    <= frame_len_d;
		end
	end

	// header / trailer byte store
	always_ff @(posedge clk) begin
		if (item_accept && hdr_we) begin
			hdr_q[hdr_wa] <= item.rx_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			result_q <= res;
		end
	end

	// checks
	a_payload_phase: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.payload_valid |-> result.phase != PHASE_HUNT)
		else $error("payload beat reported in header hunt");

	a_header_phase: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.header_accepted |-> result.phase == PHASE_PAYLOAD)
		else $error("accepted header did not enter payload");

	a_abort_phase: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_abort |-> result.phase == PHASE_HUNT)
		else $error("abort did not restart hunt");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0({result.payload_valid, result.header_accepted,
			result.length_rejected, result.frame_complete, result.frame_abort}))
		else $error("more than one event in a result beat");

	a_done_needs_header: assert property (@(posedge clk) disable iff (!arst_n)
		payload_done_q |-> header_ok_q)
		else $error("payload done without header");

endmodule

`default_nettype wire
